/* rtl/lcts_pkg.sv */
`default_nettype none

package lcts_pkg;

  // field widths fixed by the word formats
  localparam int unsigned RAW_BITS_DEF = 24;
  localparam int unsigned SPA_W        = 8;
  localparam int unsigned GRAMS_W      = 16;
  localparam int unsigned THR_W        = 24;
  localparam int unsigned GN_W         = SPA_W + GRAMS_W;
  localparam int unsigned WEIGHT_W     = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAMS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [SPA_W-1:0]   SAMPLES_RST   = 8'd100;
  localparam logic [GRAMS_W-1:0] GRAMS_RST     = 16'd100;
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 24'd1000;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SAT      = 2'd1;
  localparam logic [1:0] STAT_SPAN_BAD = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_POS_SAT = 16'h7FFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_NEG_SAT = 16'h8000;

  typedef enum logic [1:0] {
    PH_TARE = 2'd0,
    PH_WAIT = 2'd1,
    PH_SPAN = 2'd2,
    PH_MEAS = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic take;
    logic mul_start;
    logic div_start;
    logic emit;
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/lcts_if.sv */
`default_nettype none

interface lcts_in_if #(
  parameter int unsigned RAW_W = 24
);
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_word;
  logic             recalibrate;

  modport source (output valid, output raw_word, output recalibrate, input ready);
  modport sink   (input valid, input raw_word, input recalibrate, output ready);
endinterface

interface lcts_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        phase;
  logic signed [15:0] weight;
  logic              weight_valid;
  logic [1:0]        status;

  modport source (output valid, output phase, output weight, output weight_valid,
                  output status, input ready);
  modport sink   (input valid, input phase, input weight, input weight_valid,
                  input status, output ready);
endinterface

`default_nettype wire

/* rtl/lcts_mul.sv */
`default_nettype none

// Shift-add multiplier: one bit of b per cycle.
module lcts_mul
  import lcts_pkg::*;
#(
  parameter int unsigned A_W = RAW_BITS_DEF + SPA_W,
  parameter int unsigned B_W = GN_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic                    done_o,
  output logic [A_W+B_W-1:0]      prod_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_q;
  logic [P_W-1:0]   p_q, p_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [A_W:0]     sum;

  // low half holds the multiplier bits still to go, high half the partial sum
  always_comb begin
    sum = {1'b0, p_q[P_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : {(A_W+1){1'b0}});
    p_d = {sum, p_q[B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{A_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

/* rtl/lcts_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend register
// turns into the quotient as bits shift out of its top.
module lcts_div
  import lcts_pkg::*;
#(
  parameter int unsigned NUM_W = RAW_BITS_DEF + SPA_W + GN_W,
  parameter int unsigned DEN_W = RAW_BITS_DEF + 2 * SPA_W,
  parameter int unsigned ITER_W = $clog2(NUM_W + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [ITER_W-1:0] iters_i,
  output logic                   done_o,
  output logic [NUM_W-1:0]       quot_o
);

  logic [NUM_W-1:0]  q_q;
  logic [DEN_W-1:0]  rem_q, den_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    rem_sh, den_x, trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, q_q[NUM_W-1]};
    den_x  = {1'b0, den_q};
    trial  = rem_sh - den_x;
    ge     = rem_sh >= den_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == ITER_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - ITER_W'(1);
        if (cnt_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q   <= {q_q[NUM_W-2:0], ge};
      rem_q <= ge ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

`default_nettype wire

/* rtl/load_cell_tare_span_scale.sv */
`default_nettype none

// channel   dir  handshake      payload
// in_i      in   valid/ready    raw_word[RAW_BITS], recalibrate
// out_o     out  valid/ready    phase[2], weight[16] signed, weight_valid, status[2]
// cfg       in   cfg_we_i       cfg_idx_i[2], cfg_data_i[24], write only
//
// One word at a time. A plain word passes through accept and hand-off.
// The word that closes tare runs the serial divider on tare_sum / n,
// one quotient bit per cycle.
// A measuring word with a positive span sum runs a 24-step shift-add multiply
// by grams*n, then RAW_BITS+32 divider steps by the span sum.
// Reset clears phase and accumulators; registers load their defaults.
// A result waits in the output register; the next word is taken meanwhile.
module load_cell_tare_span_scale
  import lcts_pkg::*;
#(
  parameter int unsigned RAW_BITS = RAW_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  lcts_in_if.sink                    in_i,
  lcts_out_if.source                 out_o
);

  localparam int unsigned AVG_W  = RAW_BITS + SPA_W;
  localparam int unsigned DIFF_W = AVG_W + 1;
  localparam int unsigned SPAN_W = DIFF_W + SPA_W;
  localparam int unsigned MAG_W  = AVG_W;
  localparam int unsigned NUM_W  = MAG_W + GN_W;
  localparam int unsigned DEN_W  = SPAN_W - 1;
  localparam int unsigned ITER_W = $clog2(NUM_W + 1);

  // configuration
  logic [SPA_W-1:0]   spa_q;
  logic [GRAMS_W-1:0] grams_q;
  logic [THR_W-1:0]   thr_q;
  logic [SPA_W-1:0]   n;

  // calibration state
  phase_e             phase_q;
  logic [SPA_W-1:0]   cnt_q;
  logic [AVG_W-1:0]   acc_q;
  logic [AVG_W-1:0]   tare_q;
  logic signed [SPAN_W-1:0] span_q;

  // word in flight
  phase_e             item_ph_q;
  logic               recal_q;
  logic               neg_q;
  logic [WEIGHT_W-1:0] res_weight_q;
  logic               res_valid_q;
  logic [1:0]         res_status_q;

  // output register
  logic               out_valid_q;
  logic [1:0]         out_phase_q;
  logic [WEIGHT_W-1:0] out_weight_q;
  logic               out_wvalid_q;
  logic [1:0]         out_status_q;
  logic               out_free;

  state_e             state_q, state_d;
  ctl_t               ctl;

  logic [RAW_BITS-1:0]      count;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag_full;
  logic [SPAN_W-1:0]        diff_x;
  logic [AVG_W-1:0]         acc_sum;
  logic [SPA_W:0]           cnt_inc;
  logic                     last, thr_ok, span_pos, neg;
  logic [GN_W-1:0]          gn;

  logic                     mul_done, div_done;
  logic [NUM_W-1:0]         prod, quot, num_sel;
  logic [DEN_W-1:0]         den_sel;
  logic [ITER_W-1:0]        iters_sel;
  logic                     sat_pos, sat_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spa_q   <= SAMPLES_RST;
      grams_q <= GRAMS_RST;
      thr_q   <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SAMPLES:   spa_q   <= cfg_data_i[SPA_W-1:0];
        REG_GRAMS:     grams_q <= cfg_data_i[GRAMS_W-1:0];
        REG_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // zero samples behaves as one
  assign n = (spa_q == '0) ? SPA_W'(1) : spa_q;

  always_comb begin
    count    = {~in_i.raw_word[RAW_BITS-1], in_i.raw_word[RAW_BITS-2:0]};
    diff     = $signed({1'b0, tare_q}) - $signed({{(DIFF_W-RAW_BITS){1'b0}}, count});
    neg      = diff[DIFF_W-1];
    mag_full = neg ? (DIFF_W'(0) - diff) : diff;
    diff_x   = {{(SPAN_W-DIFF_W){diff[DIFF_W-1]}}, diff};
    acc_sum  = acc_q + AVG_W'(count);
    cnt_inc  = {1'b0, cnt_q} + (SPA_W+1)'(1);
    last     = cnt_inc >= {1'b0, n};
    thr_ok   = diff >= $signed({{(DIFF_W-THR_W){1'b0}}, thr_q});
    span_pos = !span_q[SPAN_W-1] && (span_q != '0);
    gn       = {{SPA_W{1'b0}}, grams_q} * {{GRAMS_W{1'b0}}, n};
  end

  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (phase_q == PH_TARE && last) begin
            state_d = ST_DIV;
          end else if (phase_q == PH_MEAS && span_pos) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_MUL:  if (mul_done) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // controls
  always_comb begin
    ctl           = '0;
    ctl.in_ready  = (state_q == ST_IDLE);
    ctl.take      = ctl.in_ready && in_i.valid;
    ctl.mul_start = ctl.take && (phase_q == PH_MEAS) && span_pos;
    ctl.div_start = (ctl.take && (phase_q == PH_TARE) && last) ||
                    ((state_q == ST_MUL) && mul_done);
    ctl.emit      = (state_q == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  lcts_mul #(
    .A_W (MAG_W),
    .B_W (GN_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.mul_start),
    .a_i     (mag_full[MAG_W-1:0]),
    .b_i     (gn),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // tare: sum sits in the top AVG_W bits, only AVG_W steps needed
  always_comb begin
    if (state_q == ST_MUL) begin
      num_sel   = prod;
      den_sel   = span_q[DEN_W-1:0];
      iters_sel = ITER_W'(NUM_W);
    end else begin
      num_sel   = {acc_sum, {(NUM_W-AVG_W){1'b0}}};
      den_sel   = DEN_W'(n);
      iters_sel = ITER_W'(AVG_W);
    end
  end

  lcts_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .ITER_W (ITER_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.div_start),
    .num_i   (num_sel),
    .den_i   (den_sel),
    .iters_i (iters_sel),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign sat_pos = quot > NUM_W'(WEIGHT_POS_SAT);
  assign sat_neg = quot > NUM_W'(WEIGHT_NEG_SAT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TARE;
      cnt_q        <= '0;
      acc_q        <= '0;
      tare_q       <= '0;
      span_q       <= '0;
      item_ph_q    <= PH_TARE;
      recal_q      <= 1'b0;
      neg_q        <= 1'b0;
      res_weight_q <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= STAT_OK;
    end else begin
      if (ctl.take) begin
        item_ph_q    <= phase_q;
        recal_q      <= in_i.recalibrate;
        neg_q        <= neg;
        res_weight_q <= '0;
        res_valid_q  <= 1'b0;
        res_status_q <= (phase_q == PH_MEAS && !span_pos) ? STAT_SPAN_BAD : STAT_OK;
        unique case (phase_q)
          PH_TARE: begin
            acc_q <= acc_sum;
            cnt_q <= last ? '0 : cnt_inc[SPA_W-1:0];
          end
          PH_WAIT: begin
            if (thr_ok) begin
              span_q  <= '0;
              cnt_q   <= '0;
              phase_q <= PH_SPAN;
            end
          end
          PH_SPAN: begin
            span_q <= span_q + $signed(diff_x);
            if (last) begin
              cnt_q   <= '0;
              phase_q <= PH_MEAS;
            end else begin
              cnt_q <= cnt_inc[SPA_W-1:0];
            end
          end
          PH_MEAS: ;
          default: ;
        endcase
      end

      if (div_done) begin
        if (item_ph_q == PH_TARE) begin
          tare_q  <= quot[AVG_W-1:0];
          phase_q <= PH_WAIT;
        end else begin
          res_valid_q <= 1'b1;
          priority if (!neg_q && sat_pos) begin
            res_weight_q <= WEIGHT_POS_SAT;
            res_status_q <= STAT_SAT;
          end else if (neg_q && sat_neg) begin
            res_weight_q <= WEIGHT_NEG_SAT;
            res_status_q <= STAT_SAT;
          end else begin
            res_weight_q <= neg_q ? (WEIGHT_W'(0) - quot[WEIGHT_W-1:0])
                                  : quot[WEIGHT_W-1:0];
            res_status_q <= STAT_OK;
          end
        end
      end

      // recalibrate lands after the word's own update
      if (ctl.emit && recal_q) begin
        phase_q <= PH_TARE;
        cnt_q   <= '0;
        acc_q   <= '0;
        tare_q  <= '0;
        span_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_phase_q  <= item_ph_q;
      out_weight_q <= res_weight_q;
      out_wvalid_q <= res_valid_q;
      out_status_q <= res_status_q;
    end
  end

  assign in_i.ready         = ctl.in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.phase        = out_phase_q;
  assign out_o.weight       = $signed(out_weight_q);
  assign out_o.weight_valid = out_wvalid_q;
  assign out_o.status       = out_status_q;

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.take |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL))
    else $error("multiplier finished outside multiply state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");

  a_weight_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_wvalid_q) |-> (out_phase_q == PH_MEAS))
    else $error("weight marked valid outside measuring phase");

endmodule

`default_nettype wire

/* dv/testbench.sv */
module testbench;
  import lcts_pkg::*;

  localparam int     WORD_TOTAL  = 1450;
  localparam int     CALM_WORDS  = 150;
  localparam int     CYCLE_LIMIT = 800_000;
  localparam longint COUNT_MAX   = 'hFFFFFF;

  typedef struct packed {
    phase_e             phase;
    logic signed [15:0] weight;
    logic               weight_valid;
    logic [1:0]         status;
  } reading_t;

  typedef struct {
    bit          cfg;
    logic [7:0]  spa;
    logic [15:0] grams;
    logic [23:0] thr;
    logic [23:0] raw;
    logic        recal;
    bit          typed;
    reading_t    want;
  } drill_t;

  localparam reading_t R_TARE     = '{PH_TARE, 16'sd0, 1'b0, STAT_OK};
  localparam reading_t R_WAIT     = '{PH_WAIT, 16'sd0, 1'b0, STAT_OK};
  localparam reading_t R_SPAN     = '{PH_SPAN, 16'sd0, 1'b0, STAT_OK};
  localparam reading_t R_SPAN_BAD = '{PH_MEAS, 16'sd0, 1'b0, STAT_SPAN_BAD};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  take_rdy = 1'b0;

  lcts_in_if #(.RAW_W(24)) word_in ();
  lcts_out_if              reading_out ();

  assign reading_out.ready = take_rdy;

  load_cell_tare_span_scale #(.RAW_BITS(24)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (word_in),
    .out_o      (reading_out)
  );

  always #2 clk_i = ~clk_i;

  // predictor state and register copies
  phase_e      cal_phase = PH_TARE;
  logic [7:0]  cal_cnt   = '0;
  longint      tare_sum  = 0;
  longint      tare_avg  = 0;
  longint      span_acc  = 0;
  logic [7:0]  spa_reg   = SAMPLES_RST;
  logic [15:0] grams_reg = GRAMS_RST;
  logic [23:0] thr_reg   = THRESHOLD_RST;

  reading_t readings_due[$];
  reading_t got;

  int  errors = 0, checked = 0, words_sent = 0, sessions = 0;
  int  weighed = 0, saturated = 0, span_faults = 0;
  int  cycles = 0, stall_left = 0, gap_pct = 0, stall_pct = 0;
  bit  calm = 1'b0;

  drill_t drills [25] = '{
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'hFFFFFF, 1'b0, 1'b1, R_TARE},
    // lowers the count while tare is under way at the default setting
    '{1'b1, 8'd2,   16'd100,   24'd1000,    24'h7FFFFF, 1'b0, 1'b1, R_TARE},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h3FFFFF, 1'b0, 1'b1, R_WAIT},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h000000, 1'b0, 1'b1, R_WAIT},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h3FFF00, 1'b0, 1'b1, R_SPAN},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h3FFF00, 1'b0, 1'b1, R_SPAN},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h3FFF00, 1'b0, 1'b1,
      '{PH_MEAS, 16'sd100, 1'b1, STAT_OK}},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h3FFFFF, 1'b0, 1'b1,
      '{PH_MEAS, 16'sd0, 1'b1, STAT_OK}},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h000000, 1'b0, 1'b1,
      '{PH_MEAS, WEIGHT_POS_SAT, 1'b1, STAT_SAT}},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h7FFFFF, 1'b0, 1'b1,
      '{PH_MEAS, WEIGHT_NEG_SAT, 1'b1, STAT_SAT}},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h400100, 1'b0, 1'b0, R_TARE},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h3FFF00, 1'b1, 1'b1,
      '{PH_MEAS, 16'sd100, 1'b1, STAT_OK}},
    // count of zero acts as one; span goes negative
    '{1'b1, 8'd0,   16'd1,     24'd0,       24'h800005, 1'b0, 1'b1, R_TARE},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h800005, 1'b0, 1'b1, R_WAIT},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h800006, 1'b0, 1'b1, R_SPAN},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h800000, 1'b0, 1'b1, R_SPAN_BAD},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h000000, 1'b1, 1'b1, R_SPAN_BAD},
    // full-scale tare against the largest threshold
    '{1'b1, 8'd5,   16'd65535, 24'hFFFFFF,  24'h7FFFFF, 1'b0, 1'b1, R_TARE},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h7FFFFF, 1'b0, 1'b1, R_TARE},
    '{1'b1, 8'd3,   16'd65535, 24'hFFFFFF,  24'h7FFFFF, 1'b0, 1'b1, R_TARE},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h800000, 1'b0, 1'b1, R_WAIT},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h800000, 1'b0, 1'b1, R_SPAN},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h800000, 1'b0, 1'b1, R_SPAN},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h800000, 1'b0, 1'b1, R_SPAN},
    '{1'b0, 8'd0,   16'd0,     24'd0,       24'h800000, 1'b1, 1'b1,
      '{PH_MEAS, WEIGHT_POS_SAT, 1'b1, STAT_SAT}}
  };

  function automatic reading_t weigh_word(logic [23:0] raw, logic recal);
    longint   cnt, n, diff, mag, q;
    reading_t r;
    cnt  = longint'(raw ^ 24'h800000);
    n    = (spa_reg == 0) ? 1 : longint'(spa_reg);
    diff = tare_avg - cnt;
    r    = '{cal_phase, 16'sd0, 1'b0, STAT_OK};
    case (cal_phase)
      PH_TARE: begin
        tare_sum += cnt;
        if (longint'(cal_cnt) + 1 >= n) begin
          tare_avg  = tare_sum / n;
          cal_cnt   = '0;
          cal_phase = PH_WAIT;
        end else begin
          cal_cnt++;
        end
      end
      PH_WAIT: begin
        // the word that triggers is not part of the span sum
        if (diff >= longint'(thr_reg)) begin
          span_acc  = 0;
          cal_cnt   = '0;
          cal_phase = PH_SPAN;
        end
      end
      PH_SPAN: begin
        span_acc += diff;
        if (longint'(cal_cnt) + 1 >= n) begin
          cal_cnt   = '0;
          cal_phase = PH_MEAS;
        end else begin
          cal_cnt++;
        end
      end
      default: begin
        if (span_acc <= 0) begin
          r.status = STAT_SPAN_BAD;
        end else begin
          mag = (diff < 0) ? -diff : diff;
          q   = mag * longint'(grams_reg) * n / span_acc;
          r.weight_valid = 1'b1;
          if (diff >= 0 && q > 32767) begin
            r.weight = WEIGHT_POS_SAT;
            r.status = STAT_SAT;
          end else if (diff < 0 && q > 32768) begin
            r.weight = WEIGHT_NEG_SAT;
            r.status = STAT_SAT;
          end else begin
            r.weight = 16'((diff < 0) ? -q : q);
          end
        end
      end
    endcase
    if (recal) begin
      cal_phase = PH_TARE;
      cal_cnt   = '0;
      tare_sum  = 0;
      tare_avg  = 0;
      span_acc  = 0;
    end
    return r;
  endfunction

  function automatic logic [23:0] raw_of(longint c);
    if (c < 0) c = 0;
    if (c > COUNT_MAX) c = COUNT_MAX;
    return c[23:0] ^ 24'h800000;
  endfunction

  task automatic send_word(logic [23:0] raw, logic recal, bit typed, reading_t want);
    reading_t calc;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      word_in.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    word_in.valid       <= 1'b1;
    word_in.raw_word    <= raw;
    word_in.recalibrate <= recal;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
    calc = weigh_word(raw, recal);
    readings_due.push_back(typed ? want : calc);
    words_sent++;
  endtask

  // block is idle once every word has its result back
  task automatic drain_readings();
    word_in.valid <= 1'b0;
    @(posedge clk_i);
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [2:0] which, logic [7:0] s, logic [15:0] g,
                            logic [23:0] t);
    if (which[0]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_SAMPLES;
      cfg_data <= CFG_DATA_W'(s);
      @(posedge clk_i);
      spa_reg = s;
    end
    if (which[1]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_GRAMS;
      cfg_data <= CFG_DATA_W'(g);
      @(posedge clk_i);
      grams_reg = g;
    end
    if (which[2]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_THRESHOLD;
      cfg_data <= t;
      @(posedge clk_i);
      thr_reg = t;
    end
    cfg_we <= 1'b0;
  endtask

  // result side: check each accepted word, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && reading_out.valid && take_rdy) begin
      got.phase        = phase_e'(reading_out.phase);
      got.weight       = reading_out.weight;
      got.weight_valid = reading_out.weight_valid;
      got.status       = reading_out.status;
      checked++;
      weighed     += got.weight_valid;
      saturated   += (got.status == STAT_SAT);
      span_faults += (got.status == STAT_SPAN_BAD);
      if (readings_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: phase %0d weight %0d valid %0b status %0d",
                   got.phase, got.weight, got.weight_valid, got.status);
      end else if (got !== readings_due[0]) begin
        errors++;
        if (errors <= 10)
          $display("result %0d mismatch: expected phase %0d weight %0d valid %0b status %0d,",
                   checked, readings_due[0].phase, readings_due[0].weight,
                   readings_due[0].weight_valid, readings_due[0].status,
                   " got phase %0d weight %0d valid %0b status %0d",
                   got.phase, got.weight, got.weight_valid, got.status);
        void'(readings_due.pop_front());
      end else begin
        void'(readings_due.pop_front());
      end
    end
    if (!rst_ni) begin
      take_rdy <= 1'b0;
    end else if (stall_left != 0 && !calm) begin
      stall_left--;
      take_rdy <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 8);
      take_rdy <= 1'b0;
    end else begin
      take_rdy <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int          row, meas_left;
    longint      cnt, load, abs_load, room;
    int unsigned spread;
    logic [23:0] base, raw, t_new;
    logic [15:0] g_new;
    logic [7:0]  s_new;
    logic [2:0]  which;
    logic        recal;
    bit          done;

    word_in.valid       = 1'b0;
    word_in.raw_word    = '0;
    word_in.recalibrate = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 20;
    stall_pct = 20;
    for (row = 0; row < 25; row++) begin
      if (drills[row].cfg) begin
        drain_readings();
        set_config(3'b111, drills[row].spa, drills[row].grams, drills[row].thr);
      end
      send_word(drills[row].raw, drills[row].recal, drills[row].typed, drills[row].want);
    end

    // random calibration sessions, each closed by a recalibrate word
    while (words_sent < WORD_TOTAL) begin
      drain_readings();
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      case ($urandom_range(0, 9))
        0:       s_new = 8'd0;
        1:       s_new = 8'd1;
        2:       s_new = 8'($urandom_range(9, 40));
        default: s_new = 8'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       g_new = 16'd1;
        1:       g_new = 16'hFFFF;
        default: g_new = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 19))
        0, 1:    t_new = 24'd0;
        2:       t_new = 24'hFFFFFF;
        default: t_new = 24'($urandom_range(0, 'h40000));
      endcase
      which = (sessions == 0) ? 3'b111 : 3'($urandom_range(0, 7));
      if (sessions == 3) begin
        s_new    = 8'd255;
        which[0] = 1'b1;
      end
      set_config(which, s_new, g_new, t_new);
      sessions++;

      base   = (thr_reg > 24'hFF0000) ? 24'hFFFFFF : 24'($urandom_range(thr_reg, 'hFFFFFF));
      spread = (thr_reg > 24'hFF0000) ? 0 : $urandom_range(0, 'h7FF);
      if ($urandom_range(0, 6) == 0) load = -longint'($urandom_range(0, 'h100));
      else load = longint'(thr_reg) + longint'($urandom_range(0, 'h8000));
      abs_load  = (load < 0) ? -load : load;
      meas_left = $urandom_range(3, 12);
      done      = 1'b0;

      while (!done && words_sent < WORD_TOTAL) begin
        calm  = (words_sent >= WORD_TOTAL - CALM_WORDS);
        recal = 1'b0;
        if ((cal_phase == PH_TARE || cal_phase == PH_SPAN) && cal_cnt != 0 &&
            $urandom_range(0, 59) == 0) begin
          drain_readings();
          set_config(3'b001, 8'($urandom_range(0, cal_cnt + 2)), '0, '0);
        end
        if ($urandom_range(0, 19) == 0) begin
          raw   = 24'($urandom);
          recal = ($urandom_range(0, 9) == 0);
        end else begin
          case (cal_phase)
            PH_TARE: begin
              cnt   = longint'(base) + longint'($urandom_range(0, 2 * spread)) - spread;
              recal = ($urandom_range(0, 99) == 0);
            end
            PH_WAIT: begin
              if (tare_avg < longint'(thr_reg) || tare_avg > COUNT_MAX) begin
                // load can never reach the threshold: start over
                cnt   = longint'($urandom_range(0, 'hFFFFFF));
                recal = 1'b1;
              end else if ($urandom_range(0, 2) == 0) begin
                if (thr_reg == 0) cnt = tare_avg + longint'($urandom_range(1, 'h100));
                else cnt = tare_avg - longint'($urandom_range(0, thr_reg - 1));
              end else begin
                room = tare_avg - longint'(thr_reg);
                if (room > 'hFFFF) room = 'hFFFF;
                cnt = tare_avg - longint'(thr_reg)
                      - longint'($urandom_range(0, int'(room)));
              end
            end
            PH_SPAN: cnt = tare_avg - load + longint'($urandom_range(0, 'h7E)) - 'h3F;
            default: begin
              case ($urandom_range(0, 3))
                0, 1: cnt = tare_avg + 2 * abs_load
                            - longint'($urandom_range(0, int'(4 * abs_load + 2)));
                2:    cnt = tare_avg + longint'($urandom_range(0, 32)) - 16;
                default: cnt = longint'($urandom_range(0, 'hFFFFFF));
              endcase
              meas_left--;
              recal = (meas_left <= 0);
            end
          endcase
          raw = raw_of(cnt);
        end
        send_word(raw, recal, 1'b0, R_TARE);
        if (recal) done = 1'b1;
      end
    end

    word_in.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("%0d words over %0d calibration sessions, %0d results checked",
             words_sent, sessions, checked);
    $display("measuring: %0d weights, %0d clamped, %0d bad span sums",
             weighed, saturated, span_faults);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lcts_pkg.sv
rtl/lcts_if.sv
rtl/lcts_mul.sv
rtl/lcts_div.sv
rtl/load_cell_tare_span_scale.sv
dv/testbench.sv
